// File: rtl/core/fsss_pkg.sv
// Shared types, constants and decode functions for the seven-segment scanner.
`timescale 1ns / 1ps

package fsss_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned POS_W = 2;
  localparam int unsigned ENABLE_W = 4;
  localparam int unsigned SEG_W = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // Reciprocal of ten for a 16-bit dividend: q = (v * DIV10_MUL) >> DIV10_SHIFT.
  localparam logic [VALUE_W-1:0] DIV10_MUL = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [VALUE_W-1:0] value;
  } item_t;

  localparam logic [SEG_W-1:0] SEG_0 = 8'b01111110;
  localparam logic [SEG_W-1:0] SEG_1 = 8'b00001100;
  localparam logic [SEG_W-1:0] SEG_2 = 8'b10110110;
  localparam logic [SEG_W-1:0] SEG_3 = 8'b10011110;
  localparam logic [SEG_W-1:0] SEG_4 = 8'b11001100;
  localparam logic [SEG_W-1:0] SEG_5 = 8'b11011010;
  localparam logic [SEG_W-1:0] SEG_6 = 8'b11111010;
  localparam logic [SEG_W-1:0] SEG_7 = 8'b00001110;
  localparam logic [SEG_W-1:0] SEG_8 = 8'b11111110;
  localparam logic [SEG_W-1:0] SEG_9 = 8'b11011110;
  localparam logic [SEG_W-1:0] SEG_BLANK = 8'b00000000;

  localparam logic [ENABLE_W-1:0] ENABLE_POS0 = 4'd14;
  localparam logic [ENABLE_W-1:0] ENABLE_POS1 = 4'd13;
  localparam logic [ENABLE_W-1:0] ENABLE_POS2 = 4'd11;
  localparam logic [ENABLE_W-1:0] ENABLE_POS3 = 4'd7;

  localparam logic [POS_W-1:0] POS_POINT = 2'd1;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    unique case (digit)
      4'd0: seg = SEG_0;
      4'd1: seg = SEG_1;
      4'd2: seg = SEG_2;
      4'd3: seg = SEG_3;
      4'd4: seg = SEG_4;
      4'd5: seg = SEG_5;
      4'd6: seg = SEG_6;
      4'd7: seg = SEG_7;
      4'd8: seg = SEG_8;
      4'd9: seg = SEG_9;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  function automatic logic [ENABLE_W-1:0] enable_pattern(input logic [POS_W-1:0] pos);
    logic [ENABLE_W-1:0] en;
    unique case (pos)
      2'd0: en = ENABLE_POS0;
      2'd1: en = ENABLE_POS1;
      2'd2: en = ENABLE_POS2;
      default: en = ENABLE_POS3;
    endcase
    return en;
  endfunction

endpackage

// File: rtl/core/fsss_front.sv
// Input side: classifies incoming requests and holds them in a short queue.
`timescale 1ns / 1ps

module fsss_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [fsss_pkg::VALUE_W-1:0] s_tdata,
  input  logic                         s_tuser,
  output logic                         head_valid,
  input  logic                         head_ready,
  output fsss_pkg::item_t              head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fsss_pkg::item_t entries [DEPTH];
  fsss_pkg::item_t incoming;

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  always_comb begin
    incoming.kind = s_tuser ? fsss_pkg::KIND_TICK : fsss_pkg::KIND_LOAD;
    incoming.value = s_tdata;
  end

  assign s_tready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];
  assign push = s_tvalid && s_tready;
  assign pop = head_valid && head_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/fsss_back.sv
// Execution side: decimal conversion of loads, digit scan and output register.
`timescale 1ns / 1ps

module fsss_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  output logic                            head_ready,
  input  fsss_pkg::item_t                 head,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fsss_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned Q_W = 2 * fsss_pkg::VALUE_W - fsss_pkg::DIV10_SHIFT;

  typedef enum logic {
    ST_READY,
    ST_CONVERT
  } state_t;

  state_t state;
  logic [fsss_pkg::POS_W-1:0] step;
  logic [fsss_pkg::VALUE_W-1:0] work;
  logic [fsss_pkg::DIGIT_W-1:0] digits [fsss_pkg::NUM_DIGITS];
  logic [fsss_pkg::POS_W-1:0] pos;
  logic [fsss_pkg::ENABLE_W-1:0] out_enable;
  logic [fsss_pkg::SEG_W-1:0] out_seg;
  logic out_point;

  logic [2*fsss_pkg::VALUE_W-1:0] product;
  logic [Q_W-1:0] quotient;
  logic [fsss_pkg::VALUE_W-1:0] quotient_ext;
  logic [fsss_pkg::VALUE_W-1:0] remainder;
  logic out_free;
  logic take;

  // One decimal digit per cycle: quotient by reciprocal multiply, remainder by shifts.
  assign product = (2*fsss_pkg::VALUE_W)'(work) * (2*fsss_pkg::VALUE_W)'(fsss_pkg::DIV10_MUL);
  assign quotient = product[2*fsss_pkg::VALUE_W-1:fsss_pkg::DIV10_SHIFT];
  assign quotient_ext = fsss_pkg::VALUE_W'(quotient);
  assign remainder = work - ((quotient_ext << 3) + (quotient_ext << 1));

  assign out_free = !m_tvalid || m_tready;
  assign head_ready = (state == ST_READY) &&
                      ((head.kind == fsss_pkg::KIND_LOAD) || out_free);
  assign take = head_valid && head_ready;

  assign m_tdata = {3'b000, out_point, out_seg, out_enable};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_READY;
      step <= '0;
      pos <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < fsss_pkg::NUM_DIGITS; i++) begin
        digits[i] <= '0;
      end
    end else begin
      if (take && head.kind == fsss_pkg::KIND_TICK) begin
        m_tvalid <= 1'b1;
        out_enable <= fsss_pkg::enable_pattern(pos);
        out_seg <= fsss_pkg::seg_pattern(digits[pos]);
        out_point <= (pos == fsss_pkg::POS_POINT);
        pos <= pos + 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_READY: begin
          if (take && head.kind == fsss_pkg::KIND_LOAD) begin
            work <= head.value;
            step <= fsss_pkg::POS_W'(fsss_pkg::NUM_DIGITS - 1);
            state <= ST_CONVERT;
          end
        end
        ST_CONVERT: begin
          digits[step] <= remainder[fsss_pkg::DIGIT_W-1:0];
          work <= quotient_ext;
          if (step == '0) begin
            state <= ST_READY;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: state <= ST_READY;
      endcase
    end
  end

endmodule

// File: rtl/core/four_digit_seven_segment_scanner_top.sv
// Top level of the multiplexed four-digit seven-segment display scanner.
// A request with tuser low loads a 16-bit value; the back end splits it into four
// decimal digits, one divide-by-ten step per cycle: it takes the load, then runs four
// conversion steps, and shows the thousands digit modulo ten. A request with tuser
// high is a refresh tick: it yields one result with the active-low digit enable,
// the segment byte and the decimal point for the current position, then advances
// the position 0 to 3 and around. Ticks run at one per cycle while no load
// converts, limited by the output register. Requests enter a queue of QUEUE_DEPTH
// entries, so input is taken every cycle while the queue has room, even while a
// load converts or a result waits downstream.
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fsss_pkg::VALUE_W-1:0]    s_tdata,  // [15:0] value
  input  logic                            s_tuser,  // [0] op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fsss_pkg::OUT_DATA_W-1:0] m_tdata   // [3:0] digit_enable_n,
                                                    // [11:4] segments,
                                                    // [12] decimal_point, [15:13] zero
);

  fsss_pkg::item_t head;
  logic head_valid;
  logic head_ready;

  fsss_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .head_valid(head_valid),
    .head_ready(head_ready),
    .head      (head)
  );

  fsss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head_ready(head_ready),
    .head      (head),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
